FILE: rtl/ook_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_pkg: shared types and constants of the OOK pulse-distance transmitter
// Payload structs, configuration register indexes and frame geometry.
// ----------------------------------------------------------------------------
package ook_pkg;

  localparam int FrameBits  = 32;
  localparam int BitSelW    = $clog2(FrameBits);
  localparam int BitIndexW  = $clog2(FrameBits + 2);
  localparam int PulseLenW  = 12;
  localparam int RepeatW    = 4;
  localparam int PhaseW     = 17;
  localparam int CfgDataW   = 12;

  // Gap and pause lengths in units of one pulse length
  localparam int ZeroGapMul = 4;
  localparam int OneGapMul  = 8;
  localparam int PauseMul   = 18;

  localparam logic [PulseLenW-1:0] PulseLenReset    = 12'd100;
  localparam logic [RepeatW-1:0]   RepeatTotalReset = 4'd7;

  typedef logic cfg_index_t;
  localparam cfg_index_t CfgPulseLen    = 1'b0;
  localparam cfg_index_t CfgRepeatTotal = 1'b1;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [FrameBits-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic level;
    logic busy_res;
  } out_item_t;

endpackage

FILE: rtl/ook_pulse_distance_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ook_pulse_distance_transmitter: on/off-keyed pulse-distance frame sender
// A start item loads a frame word; each tick item returns one carrier sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item): cmd = start loads payload
//   and begins a frame (ignored while busy, no result); cmd = tick advances
//   the bit timing by one sample and returns one result item.
//   Output channel (out_valid / out_stall / out_item): level is the carrier
//   sample, busy_res tells whether a transmission was running at that tick.
//   Config port (cfg_we / cfg_index / cfg_data): pulse_len and repeat_total,
//   written while no transmission is in progress.
// Result timing and throughput: a tick's result appears in the output
//   register in the cycle after its transfer. One item is taken per cycle
//   unless stalled; the sample update is one counter compare and a few flag
//   updates between the state and the result register.
// Reset: rst clears the transmitter state and the output valid flag and loads
//   pulse_len = 100, repeat_total = 7.
// Stall: while out_stall holds a full output register, in_stall is raised so
//   no item is taken; the stalled result stays unchanged.
// ----------------------------------------------------------------------------
module ook_pulse_distance_transmitter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ook_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ook_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  ook_pkg::cfg_index_t              cfg_index,
  input  logic [ook_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int FB  = ook_pkg::FrameBits;
  localparam int SW  = ook_pkg::BitSelW;
  localparam int IW  = ook_pkg::BitIndexW;
  localparam int PW  = ook_pkg::PhaseW;
  localparam int LW  = ook_pkg::PulseLenW;
  localparam int RW  = ook_pkg::RepeatW;

  logic [LW-1:0] pulse_len;
  logic [RW-1:0] repeat_total;

  logic          active, active_next;
  logic          in_pause, in_pause_next;
  logic          in_pulse, in_pulse_next;
  logic          cur_bit, cur_bit_next;
  logic [IW-1:0] bit_index, bit_index_next;
  logic [PW-1:0] phase_count, phase_count_next;
  logic [RW-1:0] repeats_done, repeats_done_next;
  logic [FB-1:0] frame_word, frame_word_next;

  logic          accept;
  logic          level_res;
  logic [PW-1:0] ph;
  logic [PW-1:0] len_pulse, len_zero, len_one, len_pause, len_gap;
  logic [SW-1:0] bit_sel;
  logic          word_bit;
  logic [RW-1:0] rep_inc;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_len    <= ook_pkg::PulseLenReset;
      repeat_total <= ook_pkg::RepeatTotalReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ook_pkg::CfgPulseLen:    pulse_len    <= cfg_data[LW-1:0];
        ook_pkg::CfgRepeatTotal: repeat_total <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Phase lengths: constant multiples become shifts and adds
  assign len_pulse = PW'(pulse_len);
  assign len_zero  = len_pulse * PW'(ook_pkg::ZeroGapMul);
  assign len_one   = len_pulse * PW'(ook_pkg::OneGapMul);
  assign len_pause = len_pulse * PW'(ook_pkg::PauseMul);

  assign bit_sel  = SW'(FB - 1) - bit_index[SW-1:0];
  assign word_bit = (bit_index < IW'(FB)) ? frame_word[bit_sel] : 1'b0;
  assign rep_inc  = repeats_done + RW'(1);
  assign len_gap  = (bit_index == IW'(FB)) ? len_pulse : (cur_bit ? len_one : len_zero);

  always_comb begin
    active_next       = active;
    in_pause_next     = in_pause;
    in_pulse_next     = in_pulse;
    cur_bit_next      = cur_bit;
    bit_index_next    = bit_index;
    phase_count_next  = phase_count;
    repeats_done_next = repeats_done;
    frame_word_next   = frame_word;
    level_res         = 1'b0;
    ph                = phase_count;

    if (accept) begin
      if (in_item.cmd == ook_pkg::CmdStart) begin
        if (!active) begin
          frame_word_next   = in_item.payload;
          bit_index_next    = '0;
          phase_count_next  = '0;
          in_pulse_next     = 1'b1;
          in_pause_next     = 1'b0;
          repeats_done_next = '0;
          cur_bit_next      = in_item.payload[FB-1];
          active_next       = 1'b1;
        end
      end else if (active) begin
        priority if (in_pause) begin
          if (ph > len_pause) begin
            in_pause_next = 1'b0;
            ph            = '0;
          end
        end else if (in_pulse) begin
          level_res = 1'b1;
          if (ph > len_pulse) begin
            ph            = '0;
            cur_bit_next  = word_bit;
            in_pulse_next = 1'b0;
          end
        end else if (bit_index > IW'(FB)) begin
          // end of frame: pause before the next repeat, or drop back to idle
          repeats_done_next = rep_inc;
          if (rep_inc < repeat_total) begin
            in_pause_next  = 1'b1;
            cur_bit_next   = 1'b0;
            bit_index_next = '0;
            ph             = '0;
            in_pulse_next  = 1'b1;
          end else begin
            active_next       = 1'b0;
            in_pause_next     = 1'b0;
            in_pulse_next     = 1'b0;
            cur_bit_next      = 1'b0;
            bit_index_next    = '0;
            ph                = '0;
            repeats_done_next = '0;
            frame_word_next   = '0;
          end
        end else begin
          if (ph > len_gap) begin
            ph             = '0;
            in_pulse_next  = 1'b1;
            bit_index_next = bit_index + IW'(1);
          end
        end
        phase_count_next = active_next ? ph + PW'(1) : ph;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      in_pause     <= 1'b0;
      in_pulse     <= 1'b0;
      cur_bit      <= 1'b0;
      bit_index    <= '0;
      phase_count  <= '0;
      repeats_done <= '0;
      frame_word   <= '0;
    end else begin
      active       <= active_next;
      in_pause     <= in_pause_next;
      in_pulse     <= in_pulse_next;
      cur_bit      <= cur_bit_next;
      bit_index    <= bit_index_next;
      phase_count  <= phase_count_next;
      repeats_done <= repeats_done_next;
      frame_word   <= frame_word_next;
    end
  end

  // Result register: load on a tick transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && in_item.cmd == ook_pkg::CmdTick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_item.cmd == ook_pkg::CmdTick) begin
      out_item.level    <= level_res;
      out_item.busy_res <= active;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the OOK pulse-distance transmitter
// A cycle-level model in the bench predicts level and busy for every sample
// tick. Each result transfer is checked against the oldest prediction. Both
// channels see random gaps and stalls. Register settings step through short
// pulses, single and repeated frames, and the widest values.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 8;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  ook_pkg::in_item_t            in_item   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  ook_pkg::out_item_t           out_item;
  logic                         cfg_we    = 1'b0;
  ook_pkg::cfg_index_t          cfg_index = ook_pkg::CfgPulseLen;
  logic [ook_pkg::CfgDataW-1:0] cfg_data  = '0;

  ook_pulse_distance_transmitter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Transmitter model state and its copy of the registers
  logic [ook_pkg::PulseLenW-1:0] mdl_pulse_len    = ook_pkg::PulseLenReset;
  logic [ook_pkg::RepeatW-1:0]   mdl_repeat_total = ook_pkg::RepeatTotalReset;
  logic                          tx_on;
  logic                          tx_rest;
  logic                          tx_mark;
  logic                          tx_bit;
  logic [ook_pkg::BitIndexW-1:0] bit_pos;
  logic [ook_pkg::PhaseW-1:0]    ph_cnt;
  logic [ook_pkg::RepeatW-1:0]   frames_sent;
  logic [ook_pkg::FrameBits-1:0] tx_word;

  ook_pkg::out_item_t pending_samples[$];

  int mismatches      = 0;
  int results_checked = 0;
  int starts_taken    = 0;
  int frames_done     = 0;
  int cfg_writes      = 0;
  int burst_left      = 0;
  bit no_gaps         = 1'b0;
  int quiet_cycles    = 0;
  int stall_mode      = 0;
  int stall_clock     = 0;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_tx_model();
    tx_on       = 1'b0;
    tx_rest     = 1'b0;
    tx_mark     = 1'b0;
    tx_bit      = 1'b0;
    bit_pos     = '0;
    ph_cnt      = '0;
    frames_sent = '0;
    tx_word     = '0;
  endtask

  // Bits past the word (sync and final pulse) read as zero
  function automatic logic word_bit_at(input int k);
    if (k >= ook_pkg::FrameBits) return 1'b0;
    return tx_word[ook_pkg::FrameBits-1-k];
  endfunction

  task automatic predict_sample(input ook_pkg::in_item_t it);
    int                 span;
    logic               lvl;
    logic               was_busy;
    ook_pkg::out_item_t smp;
    lvl      = 1'b0;
    was_busy = tx_on;
    if (it.cmd == ook_pkg::CmdStart) begin
      starts_taken++;
      if (!tx_on) begin
        tx_word     = it.payload;
        bit_pos     = '0;
        ph_cnt      = '0;
        tx_mark     = 1'b1;
        tx_rest     = 1'b0;
        frames_sent = '0;
        tx_bit      = word_bit_at(0);
        tx_on       = 1'b1;
      end
    end else begin
      if (tx_on) begin
        if (tx_rest) begin
          if (int'(ph_cnt) > int'(mdl_pulse_len) * ook_pkg::PauseMul) begin
            tx_rest = 1'b0;
            ph_cnt  = '0;
          end
        end else if (tx_mark) begin
          lvl = 1'b1;
          if (int'(ph_cnt) > int'(mdl_pulse_len)) begin
            ph_cnt  = '0;
            tx_bit  = word_bit_at(int'(bit_pos));
            tx_mark = 1'b0;
          end
        end else if (bit_pos > ook_pkg::FrameBits) begin
          // First gap sample after the final pulse closes the frame
          frames_done++;
          frames_sent = frames_sent + 1'b1;
          if (frames_sent < mdl_repeat_total) begin
            tx_rest = 1'b1;
            tx_bit  = 1'b0;
            bit_pos = '0;
            ph_cnt  = '0;
            tx_mark = 1'b1;
          end else begin
            clear_tx_model();
          end
        end else begin
          if (bit_pos == ook_pkg::FrameBits) span = int'(mdl_pulse_len);
          else span = int'(mdl_pulse_len) *
                      (tx_bit ? ook_pkg::OneGapMul : ook_pkg::ZeroGapMul);
          if (int'(ph_cnt) > span) begin
            ph_cnt  = '0;
            tx_mark = 1'b1;
            bit_pos = bit_pos + 1'b1;
          end
        end
        if (tx_on) ph_cnt = ph_cnt + 1'b1;
      end
      smp.level    = lvl;
      smp.busy_res = was_busy;
      pending_samples.push_back(smp);
    end
  endtask

  // Drive one item, hold it until the transfer, then predict its result
  task automatic send_item(input ook_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_sample(it);
  endtask

  task automatic send_tick();
    ook_pkg::in_item_t it;
    it.cmd     = ook_pkg::CmdTick;
    it.payload = $urandom;
    send_item(it);
  endtask

  task automatic send_start(input logic [ook_pkg::FrameBits-1:0] word);
    ook_pkg::in_item_t it;
    it.cmd     = ook_pkg::CmdStart;
    it.payload = word;
    send_item(it);
  endtask

  function automatic logic [ook_pkg::FrameBits-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic finish_transmission();
    while (tx_on) send_tick();
  endtask

  // Let all results drain before touching a register
  task automatic write_reg(input ook_pkg::cfg_index_t idx,
                           input logic [ook_pkg::CfgDataW-1:0] val);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ook_pkg::CfgPulseLen) mdl_pulse_len = val[ook_pkg::PulseLenW-1:0];
    else mdl_repeat_total = val[ook_pkg::RepeatW-1:0];
    cfg_writes++;
  endtask

  task automatic run_traffic(input logic [ook_pkg::PulseLenW-1:0] plen,
                             input logic [ook_pkg::RepeatW-1:0] reps,
                             input int count, input bit complete);
    bit do_start;
    write_reg(ook_pkg::CfgPulseLen, ook_pkg::CfgDataW'(plen));
    write_reg(ook_pkg::CfgRepeatTotal, ook_pkg::CfgDataW'(reps));
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      // Mostly start when idle; now and then try a start while busy
      if (!tx_on) do_start = ($urandom_range(0, 3) != 0);
      else do_start = ($urandom_range(0, 15) == 0);
      if (do_start) send_start(pick_word());
      else send_tick();
    end
    if (complete) finish_transmission();
  endtask

  // Reset settings, nothing running: every tick is low and not busy
  task automatic test_idle_ticks();
    ook_pkg::in_item_t it;
    it.cmd     = ook_pkg::CmdTick;
    it.payload = '0;
    send_item(it);
    it.payload = '1;
    send_item(it);
    repeat (2) send_tick();
  endtask

  // Zero pulse length and zero repeat count: one fast frame; a start while busy is ignored
  task automatic test_short_frame();
    write_reg(ook_pkg::CfgPulseLen, '0);
    write_reg(ook_pkg::CfgRepeatTotal, '0);
    no_gaps = 1'b0;
    send_tick();
    send_start(32'h8000_0001);
    send_start('1);
    finish_transmission();
    send_tick();
  endtask

  task automatic test_bit_timing();
    run_traffic(12'd1, 4'd1, 120, 1'b1);
  endtask

  // Two frames with the pause between them
  task automatic test_repeats();
    run_traffic(12'd0, 4'd2, 120, 1'b1);
  endtask

  // Widest settings last: the frame is far too long to finish
  task automatic test_wide_settings();
    run_traffic('1, '1, 40, 1'b0);
  endtask

  always @(posedge clk) begin : check_results
    ook_pkg::out_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_samples.size() == 0) begin
        flag_error("result transfer with no sample expected");
      end else begin
        want = pending_samples.pop_front();
        results_checked++;
        if (out_item.level !== want.level)
          flag_error($sformatf("sample %0d level %b, expected %b",
                               results_checked, out_item.level, want.level));
        if (out_item.busy_res !== want.busy_res)
          flag_error($sformatf("sample %0d busy %b, expected %b",
                               results_checked, out_item.busy_res, want.busy_res));
      end
    end
  end

  // Receiver stalls: none, random, or a fixed duty pattern, with the mode switched at random
  always @(posedge clk) begin : stall_pattern
    if (rst) begin
      out_stall   <= 1'b0;
      stall_mode  <= 0;
      stall_clock <= 0;
    end else begin
      stall_clock <= stall_clock + 1;
      if (stall_clock % 48 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= (stall_clock % 7) < 3;
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("ERROR: no transfer for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_tx_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_ticks();
    test_short_frame();
    test_bit_timing();
    test_repeats();
    test_wide_settings();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    $display("Checked %0d samples over %0d starts, %0d frames closed, %0d register writes",
             results_checked, starts_taken, frames_done, cfg_writes);
    $display("Pulse lengths 0, 1 and 4095; repeat counts 0, 1, 2 and 15; starts while busy");
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: ook_pulse_distance_transmitter.f
rtl/ook_pkg.sv
rtl/ook_pulse_distance_transmitter.sv
tb/tb_top.sv
